### hw/rtl/i2cmts_pkg.sv
`timescale 1ns / 1ps

package i2cmts_pkg;

  // Width of the remaining-byte counters.
  localparam int CNT_W = 16;

  localparam int ACT_W    = 3;
  localparam int ADDR_W   = 7;
  localparam int FCNT_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int EN_W     = 6;
  localparam int CMD_W    = 2;
  localparam int WAIT_W   = 2;
  localparam int STAT_W   = 2;
  localparam int TOTAL_W  = 17;

  // Controller event codes
  localparam logic [ACT_W-1:0] ACT_BEGIN    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TX_EMPTY = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TX_END   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RX_FULL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BUS_ERR  = 3'd5;

  // Interrupt enable bits
  localparam logic [EN_W-1:0] EN_NONE  = 6'b000000;
  localparam logic [EN_W-1:0] EN_TIE   = 6'b000001;
  localparam logic [EN_W-1:0] EN_TEIE  = 6'b000010;
  localparam logic [EN_W-1:0] EN_RIE   = 6'b000100;
  localparam logic [EN_W-1:0] EN_SPIE  = 6'b001000;
  localparam logic [EN_W-1:0] EN_NAKIE = 6'b010000;
  localparam logic [EN_W-1:0] EN_TMOIE = 6'b100000;

  // Bus commands
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 2'd3;

  // WAIT control
  localparam logic [WAIT_W-1:0] WAIT_KEEP  = 2'd0;
  localparam logic [WAIT_W-1:0] WAIT_SET   = 2'd1;
  localparam logic [WAIT_W-1:0] WAIT_CLEAR = 2'd2;

  // Completion status
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_IO   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_SEND     = 4'd2,
    PH_RESTART  = 4'd3,
    PH_STOP     = 4'd4,
    PH_RX_FIRST = 4'd5,
    PH_RX       = 4'd6,
    PH_RX_LAST  = 4'd7
  } phase_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] slave_addr;
    logic [FCNT_W-1:0] send_count;
    logic [FCNT_W-1:0] recv_count;
    logic              bus_busy;
    logic [BYTE_W-1:0] tx_byte;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_data;
    logic               rx_valid;
    logic [BYTE_W-1:0]  rx_data;
    logic [EN_W-1:0]    irq_enables;
    logic [CMD_W-1:0]   bus_command;
    logic [WAIT_W-1:0]  wait_control;
    logic               nack_next;
    logic               done_res;
    logic [STAT_W-1:0]  status;
    logic [TOTAL_W-1:0] byte_total;
  } result_t;

  // Fit a count field to the counter width (truncate or zero-extend).
  function automatic logic [CNT_W-1:0] cnt_fit(input logic [FCNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (i < FCNT_W) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

  // Fit the byte sum to the reported total width.
  function automatic logic [TOTAL_W-1:0] total_fit(input logic [CNT_W:0] v);
    logic [TOTAL_W-1:0] r;
    r = '0;
    for (int i = 0; i < TOTAL_W; i++) begin
      if (i <= CNT_W) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/i2cmts_in_stage.sv
`timescale 1ns / 1ps

module i2cmts_in_stage
  import i2cmts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  down_ready,
  output logic  step,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  // Advance the held beat whenever the result register can take it.
  assign step     = valid_r && down_ready;
  assign in_ready = !valid_r || down_ready;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### hw/rtl/i2cmts_core.sv
`timescale 1ns / 1ps

module i2cmts_core
  import i2cmts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  send_r, send_nxt;
  logic [CNT_W-1:0]  recv_r, recv_nxt;
  logic [CNT_W:0]    sum_r, sum_nxt;
  logic [EN_W-1:0]   en_r, en_nxt;
  logic              fault_r, fault_nxt;

  logic [CNT_W-1:0]  scnt, rcnt, send_dec, recv_dec;
  logic              fault_stop;

  assign scnt       = cnt_fit(item.send_count);
  assign rcnt       = cnt_fit(item.recv_count);
  assign send_dec   = (send_r == '0) ? '0 : send_r - CNT_W'(1);
  assign recv_dec   = (recv_r == '0) ? '0 : recv_r - CNT_W'(1);
  assign fault_stop = fault_r || (phase_r != PH_STOP);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    send_nxt  = send_r;
    recv_nxt  = recv_r;
    sum_nxt   = sum_r;
    en_nxt    = en_r;
    fault_nxt = fault_r;
    case (item.action)
      ACT_BEGIN: begin
        if (item.bus_busy) begin
          phase_nxt = PH_IDLE;
          en_nxt    = EN_NONE;
          fault_nxt = 1'b1;
        end else begin
          phase_nxt = PH_START;
          addr_nxt  = {item.slave_addr, 1'b0};
          send_nxt  = scnt;
          recv_nxt  = rcnt;
          sum_nxt   = {1'b0, scnt} + {1'b0, rcnt};
          fault_nxt = 1'b0;
          en_nxt    = EN_TIE | EN_NAKIE | EN_TMOIE;
        end
      end
      ACT_TX_EMPTY: begin
        if (phase_r == PH_START) begin
          if (send_r != '0) begin
            phase_nxt = PH_SEND;
          end else begin
            en_nxt    = (en_r | EN_RIE) & ~EN_TIE;
            phase_nxt = PH_RX_FIRST;
          end
        end else if (phase_r == PH_SEND) begin
          send_nxt = send_dec;
          if (send_dec == '0) begin
            phase_nxt = (recv_r == '0) ? PH_STOP : PH_RESTART;
            en_nxt    = (en_r | EN_TEIE) & ~EN_TIE;
          end
        end
      end
      ACT_TX_END: begin
        if (phase_r == PH_STOP) begin
          en_nxt = (en_r & ~EN_TEIE) | EN_SPIE;
        end else if (phase_r == PH_RESTART) begin
          en_nxt    = EN_TIE | EN_NAKIE;
          phase_nxt = PH_START;
        end
      end
      ACT_RX_FULL: begin
        if (phase_r == PH_RX_FIRST) begin
          phase_nxt = (recv_r <= CNT_W'(1)) ? PH_RX_LAST : PH_RX;
        end else if (phase_r == PH_RX) begin
          if (recv_r <= CNT_W'(2)) begin
            phase_nxt = PH_RX_LAST;
          end
          recv_nxt = recv_dec;
        end else if (phase_r == PH_RX_LAST) begin
          en_nxt    = (en_r | EN_SPIE) & ~EN_RIE;
          recv_nxt  = recv_dec;
          phase_nxt = PH_STOP;
        end
      end
      ACT_STOP: begin
        if (phase_r != PH_IDLE) begin
          fault_nxt = fault_stop;
          en_nxt    = EN_NONE;
          phase_nxt = PH_IDLE;
        end
      end
      ACT_BUS_ERR: begin
        if (phase_r != PH_IDLE) begin
          fault_nxt = 1'b1;
          phase_nxt = PH_STOP;
          en_nxt    = EN_SPIE;
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields
  always_comb begin
    res              = '0;
    res.irq_enables  = en_nxt;
    res.bus_command  = CMD_NONE;
    res.wait_control = WAIT_KEEP;
    res.status       = ST_OK;
    case (item.action)
      ACT_BEGIN: begin
        if (item.bus_busy) begin
          res.done_res = 1'b1;
          res.status   = ST_BUSY;
        end else begin
          res.bus_command = CMD_START;
        end
      end
      ACT_TX_EMPTY: begin
        if (phase_r == PH_START) begin
          res.tx_valid = 1'b1;
          res.tx_data  = (send_r != '0) ? addr_r : (addr_r | BYTE_W'(1));
        end else if (phase_r == PH_SEND) begin
          res.tx_valid = 1'b1;
          res.tx_data  = item.tx_byte;
        end
      end
      ACT_TX_END: begin
        if (phase_r == PH_STOP) begin
          res.bus_command = CMD_STOP;
        end else if (phase_r == PH_RESTART) begin
          res.bus_command = CMD_RESTART;
        end
      end
      ACT_RX_FULL: begin
        if (phase_r == PH_RX_FIRST) begin
          if (recv_r <= CNT_W'(2)) begin
            res.wait_control = WAIT_SET;
          end
          res.nack_next = (recv_r <= CNT_W'(1));
        end else if (phase_r == PH_RX) begin
          if (recv_r == CNT_W'(3)) begin
            res.wait_control = WAIT_SET;
          end
          res.nack_next = (recv_r <= CNT_W'(2));
          res.rx_valid  = 1'b1;
          res.rx_data   = item.rx_byte;
        end else if (phase_r == PH_RX_LAST) begin
          res.bus_command  = CMD_STOP;
          res.rx_valid     = 1'b1;
          res.rx_data      = item.rx_byte;
          res.wait_control = WAIT_CLEAR;
        end
      end
      ACT_STOP: begin
        if (phase_r != PH_IDLE) begin
          res.done_res   = 1'b1;
          res.status     = fault_stop ? ST_IO : ST_OK;
          res.byte_total = fault_stop ? '0 : total_fit(sum_r);
        end
      end
      ACT_BUS_ERR: begin
        if (phase_r != PH_IDLE) begin
          res.bus_command = CMD_STOP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      send_r  <= '0;
      recv_r  <= '0;
      sum_r   <= '0;
      en_r    <= EN_NONE;
      fault_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      send_r  <= send_nxt;
      recv_r  <= recv_nxt;
      sum_r   <= sum_nxt;
      en_r    <= en_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

### hw/rtl/i2cmts_out_stage.sv
`timescale 1ns / 1ps

module i2cmts_out_stage
  import i2cmts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    up_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic    valid_r;
  result_t res_r;

  // Take a new beat when empty or when the current one leaves this cycle.
  assign up_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

### hw/rtl/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps

// I2C master transaction sequencer.
// Input channel (in_valid/in_ready): one controller event per beat - begin,
// tx empty, tx end, rx full, stop seen or bus error - with the begin
// arguments (address, send and receive counts, bus busy) and the data bytes.
// Output channel (out_valid/out_ready): exactly one result beat per event,
// carrying the transmit register write, the delivered receive byte, the
// interrupt enable set, the bus command, WAIT/ACKBT control and the
// completion report with status and byte count.
// From input accept to result valid, the beat lands in the input register and
// the phase logic then loads the result register once it can take the beat.
// Throughput is one event per cycle while out_ready stays high.
// A stalled receiver holds the result register; the input register still
// takes one more beat, after which in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers, returns the phase
// to idle and clears the address, counters, enable set and error flag.
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [ADDR_W-1:0]   in_slave_addr,
  input  logic [FCNT_W-1:0]   in_send_count,
  input  logic [FCNT_W-1:0]   in_recv_count,
  input  logic                in_bus_busy,
  input  logic [BYTE_W-1:0]   in_tx_byte,
  input  logic [BYTE_W-1:0]   in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_tx_valid,
  output logic [BYTE_W-1:0]   out_tx_data,
  output logic                out_rx_valid,
  output logic [BYTE_W-1:0]   out_rx_data,
  output logic [EN_W-1:0]     out_irq_enables,
  output logic [CMD_W-1:0]    out_bus_command,
  output logic [WAIT_W-1:0]   out_wait_control,
  output logic                out_nack_next,
  output logic                out_done_res,
  output logic [STAT_W-1:0]   out_status,
  output logic [TOTAL_W-1:0]  out_byte_total
);

  item_t   in_item;
  item_t   item;
  logic    step;
  logic    res_ready;
  result_t res_nxt;
  result_t res;

  // Pack the input ports into one event beat.
  assign in_item.action     = in_action;
  assign in_item.slave_addr = in_slave_addr;
  assign in_item.send_count = in_send_count;
  assign in_item.recv_count = in_recv_count;
  assign in_item.bus_busy   = in_bus_busy;
  assign in_item.tx_byte    = in_tx_byte;
  assign in_item.rx_byte    = in_rx_byte;

  // Input register: hold the event until the result register frees up.
  i2cmts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .down_ready (res_ready),
    .step       (step),
    .item       (item)
  );

  // Phase logic: advance the transaction state only when the beat moves on.
  i2cmts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res_nxt)
  );

  // Result register: hold the result while the receiver stalls.
  i2cmts_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res_nxt),
    .up_ready  (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res)
  );

  assign out_tx_valid     = res.tx_valid;
  assign out_tx_data      = res.tx_data;
  assign out_rx_valid     = res.rx_valid;
  assign out_rx_data      = res.rx_data;
  assign out_irq_enables  = res.irq_enables;
  assign out_bus_command  = res.bus_command;
  assign out_wait_control = res.wait_control;
  assign out_nack_next    = res.nack_next;
  assign out_done_res     = res.done_res;
  assign out_status       = res.status;
  assign out_byte_total   = res.byte_total;

endmodule
